FILE: rtl/cpt_pkg.sv
// Shared types and constants for the closest point on triangle core.
package cpt_pkg;

  // Default coordinate format: signed Q16.16 in 32 bits.
  localparam int COORD_WIDTH_DFLT = 32;
  localparam int FRAC_BITS_DFLT   = 16;

  // Voronoi region codes, in the order the regions are tested.
  typedef enum logic [2:0] {
    REG_VERT_A  = 3'd0,
    REG_VERT_B  = 3'd1,
    REG_EDGE_AB = 3'd2,
    REG_VERT_C  = 3'd3,
    REG_EDGE_AC = 3'd4,
    REG_EDGE_BC = 3'd5,
    REG_INSIDE  = 3'd6
  } cpt_region_t;

endpackage

FILE: rtl/closest_point_on_triangle_core.sv
// Closest point on a triangle to a query point: a fully pipelined core that takes one word
// per cycle and never asserts busy. Each accepted word produces exactly one result word (in
// Q16.16 at the default format), shown on the out_ ports for one cycle with out_strobe high;
// the receiver cannot stall, so results must be taken when they appear. Most of the pipeline
// is the two restoring dividers, which resolve one quotient bit per pipeline stage, after two
// stages of exact dot products and two stages of wide barycentric products.
module closest_point_on_triangle_core #(
  parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DFLT,
  parameter int FRAC_BITS   = cpt_pkg::FRAC_BITS_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_z,
  input  logic signed [COORD_WIDTH-1:0] in_query_x,
  input  logic signed [COORD_WIDTH-1:0] in_query_y,
  input  logic signed [COORD_WIDTH-1:0] in_query_z,
  output logic                          out_strobe,
  output logic signed [COORD_WIDTH-1:0] out_near_x,
  output logic signed [COORD_WIDTH-1:0] out_near_y,
  output logic signed [COORD_WIDTH-1:0] out_near_z,
  output logic [2:0]                    out_region
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW1  = W + 1;
  localparam int DOTW = 2 * DW1 + 2;
  localparam int VW   = 2 * DOTW + 1;
  localparam int NUMW = VW + 2;
  localparam int TW   = F + 3;
  localparam int DLAT = F + 4;
  localparam int LAT  = F + 13;
  localparam int PRW  = DW1 + TW;
  localparam int SW   = PRW + 2;

  typedef struct packed {
    logic [2:0][W-1:0]   a;
    logic [2:0][W-1:0]   b;
    logic [2:0][W-1:0]   c;
    logic [2:0][DW1-1:0] eab;
    logic [2:0][DW1-1:0] eac;
    logic [2:0][DW1-1:0] ebc;
  } geo_t;

  typedef struct packed {
    cpt_pkg::cpt_region_t region;
    logic [2:0][W-1:0]    base;
    logic [2:0][DW1-1:0]  e1;
    logic [2:0][DW1-1:0]  e2;
  } side_t;

  logic [LAT-1:0]          vld_r;
  logic signed [W-1:0]     in_a [3];
  logic signed [W-1:0]     in_b [3];
  logic signed [W-1:0]     in_c [3];
  logic signed [W-1:0]     in_p [3];
  geo_t                    geo_nxt;
  geo_t                    geo_r [6];
  logic [3*DW1-1:0]        eab_v, eac_v, pa_v, pb_v, pc_v;
  logic [3*DW1-1:0]        pa_nxt, pb_nxt, pc_nxt;
  logic [3*DW1-1:0]        pa_r, pb_r, pc_r;
  logic signed [DOTW-1:0]  d_s3 [6];
  logic signed [DOTW-1:0]  dd_r [3][6];
  logic signed [2*DOTW-1:0] m14, m32, m52, m16, m36, m54;
  logic signed [VW-1:0]    va_r, vb_r, vc_r;
  logic signed [DOTW-1:0]  d1, d2, d3, d4, d5, d6;
  logic signed [DOTW:0]    d43, d56;
  logic signed [NUMW-1:0]  vsum;
  logic signed [NUMW-1:0]  num1_nxt, den1_nxt, num2_nxt, den2_nxt;
  logic signed [NUMW-1:0]  num1_r, den1_r, num2_r, den2_r;
  side_t                   side_nxt;
  side_t                   side_r [DLAT+1];
  logic signed [TW-1:0]    t1, t2;
  logic signed [PRW-1:0]   pr1_r [3];
  logic signed [PRW-1:0]   pr2_r [3];
  logic signed [W-1:0]     sbase_r [3];
  cpt_pkg::cpt_region_t    sreg_r;
  logic signed [SW-1:0]    sum [3];
  logic signed [W-1:0]     near_nxt [3];
  logic signed [W-1:0]     near_r [3];
  cpt_pkg::cpt_region_t    region_r;

  // The pipeline never stalls, so a word is taken whenever start is high.
  assign busy = 1'b0;

  // Valid bits travel alongside the data through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  assign in_a[0] = in_vert_a_x;
  assign in_a[1] = in_vert_a_y;
  assign in_a[2] = in_vert_a_z;
  assign in_b[0] = in_vert_b_x;
  assign in_b[1] = in_vert_b_y;
  assign in_b[2] = in_vert_b_z;
  assign in_c[0] = in_vert_c_x;
  assign in_c[1] = in_vert_c_y;
  assign in_c[2] = in_vert_c_z;
  assign in_p[0] = in_query_x;
  assign in_p[1] = in_query_y;
  assign in_p[2] = in_query_z;

  // Stage 1: edge vectors and query offsets from each vertex.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geo_nxt.a[i]   = in_a[i];
      geo_nxt.b[i]   = in_b[i];
      geo_nxt.c[i]   = in_c[i];
      geo_nxt.eab[i] = DW1'(in_b[i]) - DW1'(in_a[i]);
      geo_nxt.eac[i] = DW1'(in_c[i]) - DW1'(in_a[i]);
      geo_nxt.ebc[i] = DW1'(in_c[i]) - DW1'(in_b[i]);
      pa_nxt[i*DW1 +: DW1] = DW1'(in_p[i]) - DW1'(in_a[i]);
      pb_nxt[i*DW1 +: DW1] = DW1'(in_p[i]) - DW1'(in_b[i]);
      pc_nxt[i*DW1 +: DW1] = DW1'(in_p[i]) - DW1'(in_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    geo_r[0] <= geo_nxt;
    pa_r     <= pa_nxt;
    pb_r     <= pb_nxt;
    pc_r     <= pc_nxt;
    for (int k = 1; k < 6; k++) begin
      geo_r[k] <= geo_r[k-1];
    end
  end

  assign eab_v = geo_r[0].eab;
  assign eac_v = geo_r[0].eac;
  assign pa_v  = pa_r;
  assign pb_v  = pb_r;
  assign pc_v  = pc_r;

  // Stages 2 and 3: the six dot products.
  cpt_dot #(.DW1(DW1)) u_dot1 (.clk(clk), .u_vec(eab_v), .v_vec(pa_v), .dot(d_s3[0]));
  cpt_dot #(.DW1(DW1)) u_dot2 (.clk(clk), .u_vec(eac_v), .v_vec(pa_v), .dot(d_s3[1]));
  cpt_dot #(.DW1(DW1)) u_dot3 (.clk(clk), .u_vec(eab_v), .v_vec(pb_v), .dot(d_s3[2]));
  cpt_dot #(.DW1(DW1)) u_dot4 (.clk(clk), .u_vec(eac_v), .v_vec(pb_v), .dot(d_s3[3]));
  cpt_dot #(.DW1(DW1)) u_dot5 (.clk(clk), .u_vec(eab_v), .v_vec(pc_v), .dot(d_s3[4]));
  cpt_dot #(.DW1(DW1)) u_dot6 (.clk(clk), .u_vec(eac_v), .v_vec(pc_v), .dot(d_s3[5]));

  // Stages 4 and 5: products for the barycentric terms.
  cpt_wmul #(.DW(DOTW)) u_m14 (.clk(clk), .x(d_s3[0]), .y(d_s3[3]), .p(m14));
  cpt_wmul #(.DW(DOTW)) u_m32 (.clk(clk), .x(d_s3[2]), .y(d_s3[1]), .p(m32));
  cpt_wmul #(.DW(DOTW)) u_m52 (.clk(clk), .x(d_s3[4]), .y(d_s3[1]), .p(m52));
  cpt_wmul #(.DW(DOTW)) u_m16 (.clk(clk), .x(d_s3[0]), .y(d_s3[5]), .p(m16));
  cpt_wmul #(.DW(DOTW)) u_m36 (.clk(clk), .x(d_s3[2]), .y(d_s3[5]), .p(m36));
  cpt_wmul #(.DW(DOTW)) u_m54 (.clk(clk), .x(d_s3[4]), .y(d_s3[3]), .p(m54));

  // Dot products follow the multipliers to stage 6.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      dd_r[0][i] <= d_s3[i];
      dd_r[1][i] <= dd_r[0][i];
      dd_r[2][i] <= dd_r[1][i];
    end
  end

  // Stage 6: barycentric terms.
  always_ff @(posedge clk) begin
    vc_r <= VW'(m14) - VW'(m32);
    vb_r <= VW'(m52) - VW'(m16);
    va_r <= VW'(m36) - VW'(m54);
  end

  // Stage 7: region tests in order, and the divider operands for that region.
  always_comb begin
    d1   = dd_r[2][0];
    d2   = dd_r[2][1];
    d3   = dd_r[2][2];
    d4   = dd_r[2][3];
    d5   = dd_r[2][4];
    d6   = dd_r[2][5];
    d43  = (DOTW+1)'(d4) - (DOTW+1)'(d3);
    d56  = (DOTW+1)'(d5) - (DOTW+1)'(d6);
    vsum = NUMW'(va_r) + NUMW'(vb_r) + NUMW'(vc_r);
    side_nxt.region = cpt_pkg::REG_INSIDE;
    side_nxt.base   = geo_r[5].a;
    side_nxt.e1     = geo_r[5].eab;
    side_nxt.e2     = geo_r[5].eac;
    num1_nxt = NUMW'(vb_r);
    den1_nxt = vsum;
    num2_nxt = NUMW'(vc_r);
    den2_nxt = vsum;
    if (d1 <= 0 && d2 <= 0) begin
      side_nxt.region = cpt_pkg::REG_VERT_A;
      num1_nxt = '0;
      den1_nxt = '0;
      den2_nxt = '0;
    end else if (d3 >= 0 && d4 <= d3) begin
      side_nxt.region = cpt_pkg::REG_VERT_B;
      side_nxt.base   = geo_r[5].b;
      num1_nxt = '0;
      den1_nxt = '0;
      den2_nxt = '0;
    end else if (vc_r <= 0 && d1 >= 0 && d3 <= 0) begin
      side_nxt.region = cpt_pkg::REG_EDGE_AB;
      num1_nxt = NUMW'(d1);
      den1_nxt = NUMW'(d1) - NUMW'(d3);
      den2_nxt = '0;
    end else if (d6 >= 0 && d5 <= d6) begin
      side_nxt.region = cpt_pkg::REG_VERT_C;
      side_nxt.base   = geo_r[5].c;
      num1_nxt = '0;
      den1_nxt = '0;
      den2_nxt = '0;
    end else if (vb_r <= 0 && d2 >= 0 && d6 <= 0) begin
      side_nxt.region = cpt_pkg::REG_EDGE_AC;
      side_nxt.e1     = geo_r[5].eac;
      num1_nxt = NUMW'(d2);
      den1_nxt = NUMW'(d2) - NUMW'(d6);
      den2_nxt = '0;
    end else if (va_r <= 0 && d43 >= 0 && d56 >= 0) begin
      side_nxt.region = cpt_pkg::REG_EDGE_BC;
      side_nxt.base   = geo_r[5].b;
      side_nxt.e1     = geo_r[5].ebc;
      num1_nxt = NUMW'(d43);
      den1_nxt = NUMW'(d43) + NUMW'(d56);
      den2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    num1_r    <= num1_nxt;
    den1_r    <= den1_nxt;
    num2_r    <= num2_nxt;
    den2_r    <= den2_nxt;
    side_r[0] <= side_nxt;
    for (int k = 1; k <= DLAT; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // Weights t1 and t2 along the edge vectors e1 and e2.
  cpt_div #(.NW(NUMW), .FB(F)) u_div1 (.clk(clk), .num(num1_r), .den(den1_r), .quo(t1));
  cpt_div #(.NW(NUMW), .FB(F)) u_div2 (.clk(clk), .num(num2_r), .den(den2_r), .quo(t2));

  // Scale stage: edge vectors times their weights.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pr1_r[i]   <= $signed(side_r[DLAT].e1[i]) * t1;
      pr2_r[i]   <= $signed(side_r[DLAT].e2[i]) * t2;
      sbase_r[i] <= $signed(side_r[DLAT].base[i]);
    end
    sreg_r <= side_r[DLAT].region;
  end

  // Output stage: base plus scaled offsets, saturated to the coordinate range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SW'(sbase_r[i]) + SW'(pr1_r[i] >>> F) + SW'(pr2_r[i] >>> F);
      if ((&sum[i][SW-1:W-1]) || !(|sum[i][SW-1:W-1])) begin
        near_nxt[i] = sum[i][W-1:0];
      end else if (sum[i][SW-1]) begin
        near_nxt[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        near_nxt[i] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      near_r[i] <= near_nxt[i];
    end
    region_r <= sreg_r;
  end

  assign out_strobe = vld_r[LAT-1];
  assign out_near_x = near_r[0];
  assign out_near_y = near_r[1];
  assign out_near_z = near_r[2];
  assign out_region = region_r;

endmodule

FILE: rtl/cpt_dot.sv
// Two-stage pipelined exact dot product of two signed 3-vectors.
module cpt_dot #(
  parameter int DW1 = 33
) (
  input  logic                      clk,
  input  logic [3*DW1-1:0]          u_vec,
  input  logic [3*DW1-1:0]          v_vec,
  output logic signed [2*DW1+1:0]   dot
);

  localparam int PW   = 2 * DW1;
  localparam int DOTW = PW + 2;

  logic signed [PW-1:0]   prod_r [3];
  logic signed [DOTW-1:0] dot_r;

  // First stage: one product per component.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= $signed(u_vec[i*DW1 +: DW1]) * $signed(v_vec[i*DW1 +: DW1]);
    end
  end

  // Second stage: sum of the three products at full width.
  always_ff @(posedge clk) begin
    dot_r <= DOTW'(prod_r[0]) + DOTW'(prod_r[1]) + DOTW'(prod_r[2]);
  end

  assign dot = dot_r;

endmodule

FILE: rtl/cpt_wmul.sv
// Two-stage wide signed multiplier built from four half-width partial products.
module cpt_wmul #(
  parameter int DW = 68
) (
  input  logic                   clk,
  input  logic signed [DW-1:0]   x,
  input  logic signed [DW-1:0]   y,
  output logic signed [2*DW-1:0] p
);

  localparam int H  = DW / 2;
  localparam int HW = DW - H;
  localparam int PW = 2 * DW;

  logic signed [2*HW-1:0] hh_r;
  logic signed [HW+H:0]   hl_r;
  logic signed [HW+H:0]   lh_r;
  logic [2*H-1:0]         ll_r;
  logic signed [PW-1:0]   p_r;

  // Partial products: signed high halves, unsigned low halves.
  always_ff @(posedge clk) begin
    hh_r <= $signed(x[DW-1:H]) * $signed(y[DW-1:H]);
    hl_r <= $signed(x[DW-1:H]) * $signed({1'b0, y[H-1:0]});
    lh_r <= $signed({1'b0, x[H-1:0]}) * $signed(y[DW-1:H]);
    ll_r <= x[H-1:0] * y[H-1:0];
  end

  // Recombine the partial products at their weights.
  always_ff @(posedge clk) begin
    p_r <= (PW'(hh_r) <<< (2*H)) + (PW'(hl_r) <<< H) + (PW'(lh_r) <<< H)
         + PW'($signed({1'b0, ll_r}));
  end

  assign p = p_r;

endmodule

FILE: rtl/cpt_div.sv
// Pipelined restoring divider giving a saturated, truncated fixed-point weight.
module cpt_div #(
  parameter int NW = 139,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic signed [FB+2:0] quo
);

  localparam int STEPS = FB + 2;
  localparam int RW    = NW + 1;
  localparam int TW    = FB + 3;

  logic [NW-1:0]    nmag_r, dmag_r;
  logic             neg_r, zero_r;
  logic [RW-1:0]    rem_r    [STEPS];
  logic [NW-1:0]    dvs_r    [STEPS];
  logic [STEPS-1:0] qb_r     [STEPS];
  logic             negq_r   [STEPS];
  logic             zeroq_r  [STEPS];
  logic             satq_r   [STEPS];
  logic [RW-1:0]    rem_nxt  [STEPS];
  logic [STEPS-1:0] qb_nxt   [STEPS];
  logic             sat_nxt  [STEPS];
  logic [RW-1:0]    r_in;
  logic [RW-1:0]    cmp_v;
  logic             ge;
  logic [STEPS-1:0] lim;
  logic [STEPS-1:0] qm;
  logic [STEPS-1:0] qc;
  logic [TW-1:0]    quo_nxt;
  logic signed [TW-1:0] quo_r;

  // Operand magnitudes, result sign and zero divisor flag.
  always_ff @(posedge clk) begin
    nmag_r <= num[NW-1] ? NW'(-num) : NW'(num);
    dmag_r <= den[NW-1] ? NW'(-den) : NW'(den);
    neg_r  <= num[NW-1] ^ den[NW-1];
    zero_r <= (den == '0);
  end

  // One quotient bit per stage: first against 2D, then D, then shift and D.
  always_ff @(posedge clk) begin
    rem_r[0]   <= rem_nxt[0];
    qb_r[0]    <= qb_nxt[0];
    satq_r[0]  <= sat_nxt[0];
    dvs_r[0]   <= dmag_r;
    negq_r[0]  <= neg_r;
    zeroq_r[0] <= zero_r;
    for (int j = 1; j < STEPS; j++) begin
      rem_r[j]   <= rem_nxt[j];
      qb_r[j]    <= qb_nxt[j];
      satq_r[j]  <= sat_nxt[j];
      dvs_r[j]   <= dvs_r[j-1];
      negq_r[j]  <= negq_r[j-1];
      zeroq_r[j] <= zeroq_r[j-1];
    end
  end

  always_comb begin
    r_in       = {1'b0, nmag_r};
    cmp_v      = {dmag_r, 1'b0};
    ge         = (r_in >= cmp_v);
    rem_nxt[0] = ge ? (r_in - cmp_v) : r_in;
    qb_nxt[0]  = '0;
    qb_nxt[0][STEPS-1] = ge;
    // A quotient of 2^(FB+1) (2.0) or more is flagged as saturated.
    sat_nxt[0] = ({1'b0, nmag_r, 1'b0} >= {dmag_r, 2'b00});
    for (int j = 1; j < STEPS; j++) begin
      r_in       = (j == 1) ? rem_r[j-1] : (rem_r[j-1] << 1);
      cmp_v      = {1'b0, dvs_r[j-1]};
      ge         = (r_in >= cmp_v);
      rem_nxt[j] = ge ? (r_in - cmp_v) : r_in;
      qb_nxt[j]  = qb_r[j-1];
      qb_nxt[j][STEPS-1-j] = ge;
      sat_nxt[j] = satq_r[j-1];
    end
  end

  // Clamp to magnitude 2.0, apply the sign, force zero for a zero divisor.
  always_comb begin
    lim = STEPS'(1) << (FB + 1);
    qm  = qb_r[STEPS-1];
    qc  = (satq_r[STEPS-1] || (qm > lim)) ? lim : qm;
    if (zeroq_r[STEPS-1]) begin
      quo_nxt = '0;
    end else if (negq_r[STEPS-1]) begin
      quo_nxt = -{1'b0, qc};
    end else begin
      quo_nxt = {1'b0, qc};
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= $signed(quo_nxt);
  end

  assign quo = quo_r;

endmodule

FILE: rtl/cpt_chk.sv
// Port-level checker for the closest point on triangle core, with its bind.
module cpt_chk #(
  parameter int W   = 32,
  parameter int LAT = 29
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic signed [W-1:0] in_vert_a_x,
  input logic signed [W-1:0] in_vert_a_y,
  input logic signed [W-1:0] in_vert_a_z,
  input logic signed [W-1:0] in_vert_b_x,
  input logic signed [W-1:0] in_vert_b_y,
  input logic signed [W-1:0] in_vert_b_z,
  input logic                out_strobe,
  input logic signed [W-1:0] out_near_x,
  input logic signed [W-1:0] out_near_y,
  input logic signed [W-1:0] out_near_z,
  input logic [2:0]          out_region
);

  // Every accepted word yields a result on out_strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("accepted word produced no result");

  // No result appears without a word accepted at the matching time.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result without an accepted word");

  // A vertex A result returns vertex A unchanged.
  a_vertex_a: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_region == cpt_pkg::REG_VERT_A) |->
      (out_near_x == $past(in_vert_a_x, LAT) && out_near_y == $past(in_vert_a_y, LAT) &&
       out_near_z == $past(in_vert_a_z, LAT)))
    else $error("vertex A region does not return vertex A");

  // A vertex B result returns vertex B unchanged.
  a_vertex_b: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_region == cpt_pkg::REG_VERT_B) |->
      (out_near_x == $past(in_vert_b_x, LAT) && out_near_y == $past(in_vert_b_y, LAT) &&
       out_near_z == $past(in_vert_b_z, LAT)))
    else $error("vertex B region does not return vertex B");

endmodule

bind closest_point_on_triangle_core cpt_chk #(
  .W(COORD_WIDTH),
  .LAT(FRAC_BITS + 13)
) u_cpt_chk (.*);
